FILE: src/appg_pkg.sv
// Package with the constants, register indexes and arctangent table of the pulse generator.
package appg_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int STR_W      = 32;
    localparam int TIME_W     = 32;
    localparam int HALF_W     = 31;
    localparam int PROF_W     = 20;

    localparam int XY_W     = 36;
    localparam int ANG_W    = 20;
    localparam int TAB_W    = 5;
    localparam int DIFF_W   = STR_W + 1;
    localparam int DN_W     = PROF_W + 1;
    localparam int DEN_W    = PROF_W + 1;
    localparam int PROD_W   = DIFF_W + DN_W;
    localparam int DIV_BITS = PROD_W;
    localparam int SUM_W    = DIV_BITS + 2;

    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_HALF    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_HALF    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PROFILE_MIN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PROFILE_MAX  = 3'd7;

    typedef logic signed [ANG_W-1:0] angle_t;

    // Angle of atan(2^-i) in signed Q4.16 radians, rounded to nearest.
    function automatic angle_t atan_entry(input logic [TAB_W-1:0] idx);
        angle_t ang;
        unique case (idx)
            5'd0:    ang = 20'sd51472;
            5'd1:    ang = 20'sd30386;
            5'd2:    ang = 20'sd16055;
            5'd3:    ang = 20'sd8150;
            5'd4:    ang = 20'sd4091;
            5'd5:    ang = 20'sd2047;
            5'd6:    ang = 20'sd1024;
            5'd7:    ang = 20'sd512;
            5'd8:    ang = 20'sd256;
            5'd9:    ang = 20'sd128;
            5'd10:   ang = 20'sd64;
            5'd11:   ang = 20'sd32;
            5'd12:   ang = 20'sd16;
            5'd13:   ang = 20'sd8;
            5'd14:   ang = 20'sd4;
            5'd15:   ang = 20'sd2;
            5'd16:   ang = 20'sd1;
            default: ang = 20'sd0;
        endcase
        return ang;
    endfunction

endpackage

FILE: src/arctan_pulse_profile_generator_top.sv
// Top level of the arctangent pulse profile generator with its sequencer and shared datapath.
//
// Each accepted tick request advances the running time by time_step and returns one strength
// value computed as the difference of two CORDIC arctangents, normalized between profile_min
// and profile_max and mapped linearly onto strength_min..strength_max, saturating to the signed
// 32-bit range. A restart request clears the time and returns strength_min; a tick with a zero
// profile span also returns strength_min. A single CORDIC stage runs both arctangents back to
// back, then a multiplier step and a radix-2 divider producing one quotient bit per cycle follow.
// The input is stalled while a request is in progress; the result sits in an output register so
// the next request can be taken while it waits.
module arctan_pulse_profile_generator_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [appg_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [appg_pkg::CFG_DATA_W-1:0]   wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              restart,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [appg_pkg::STR_W-1:0] strength,
    output logic [appg_pkg::TIME_W-1:0]       current_time
);
    import appg_pkg::*;

    localparam int CNT_MAX = (CORDIC_STEPS > DIV_BITS) ? CORDIC_STEPS : DIV_BITS;
    localparam int CNT_W   = $clog2(CNT_MAX);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CORDIC = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_PREP   = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_SAT    = 3'd5;
    localparam logic [2:0] ST_FIN    = 3'd6;

    logic signed [STR_W-1:0]  smin_reg;
    logic signed [STR_W-1:0]  smax_reg;
    logic [HALF_W-1:0]        width_reg;
    logic [HALF_W-1:0]        rise_reg;
    logic [HALF_W-1:0]        fall_reg;
    logic [HALF_W-1:0]        step_reg;
    logic signed [PROF_W-1:0] pmin_reg;
    logic signed [PROF_W-1:0] pmax_reg;

    logic [2:0]               state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     phase_reg, phase_next;
    logic [TIME_W-1:0]        time_reg, time_next;
    logic signed [XY_W-1:0]   x_reg, x_next;
    logic signed [XY_W-1:0]   y_reg, y_next;
    logic signed [ANG_W-1:0]  z_reg, z_next;
    logic signed [ANG_W-1:0]  zr_reg, zr_next;
    logic signed [ANG_W-1:0]  d_reg, d_next;
    logic [PROD_W-1:0]        acc_reg, acc_next;
    logic [DEN_W-1:0]         rem_reg, rem_next;
    logic [DEN_W-1:0]         den_reg, den_next;
    logic                     neg_reg, neg_next;
    logic signed [STR_W-1:0]  res_reg, res_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [STR_W-1:0]  strength_reg, strength_next;
    logic [TIME_W-1:0]        otime_reg, otime_next;

    logic [HALF_W-1:0]        w_eff;
    logic [TIME_W-1:0]        time_adv;
    logic signed [XY_W-1:0]   xs, ys, x_step, y_step;
    logic signed [ANG_W-1:0]  tab_ang, z_step;
    logic signed [DEN_W-1:0]  span;
    logic signed [DIFF_W-1:0] sdiff;
    logic signed [DN_W-1:0]   dn;
    logic signed [PROD_W-1:0] prod;
    logic [DEN_W:0]           rem_sh;
    logic [DEN_W:0]           rem_sub;
    logic signed [SUM_W-1:0]  q_signed, sum;
    logic                     out_free;

    assign w_eff    = (width_reg == '0) ? HALF_W'(1) : width_reg;
    assign time_adv = time_reg + {1'b0, step_reg};
    assign xs       = x_reg >>> cnt_reg[TAB_W-1:0];
    assign ys       = y_reg >>> cnt_reg[TAB_W-1:0];
    assign tab_ang  = atan_entry(cnt_reg[TAB_W-1:0]);
    assign x_step   = y_reg[XY_W-1] ? (x_reg - ys) : (x_reg + ys);
    assign y_step   = y_reg[XY_W-1] ? (y_reg + xs) : (y_reg - xs);
    assign z_step   = y_reg[XY_W-1] ? (z_reg - tab_ang) : (z_reg + tab_ang);
    assign span     = DEN_W'(pmax_reg) - DEN_W'(pmin_reg);
    assign sdiff    = DIFF_W'(smax_reg) - DIFF_W'(smin_reg);
    assign dn       = DN_W'(d_reg) - DN_W'(pmin_reg);
    assign prod     = sdiff * dn;
    assign rem_sh   = {1'b0, rem_reg[DEN_W-2:0], acc_reg[PROD_W-1]};
    assign rem_sub  = rem_sh - {1'b0, den_reg};
    assign q_signed = neg_reg ? -$signed({2'b00, acc_reg}) : $signed({2'b00, acc_reg});
    assign sum      = SUM_W'(smin_reg) + q_signed;
    assign out_free = !out_valid_reg || !out_stall;

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign strength     = strength_reg;
    assign current_time = otime_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smin_reg  <= '0;
            smax_reg  <= 32'sd65536;
            width_reg <= 31'd65536;
            rise_reg  <= '0;
            fall_reg  <= 31'd65536;
            step_reg  <= 31'd65536;
            pmin_reg  <= '0;
            pmax_reg  <= 20'sd205887;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_STRENGTH_MIN: smin_reg  <= wr_data[STR_W-1:0];
                REG_STRENGTH_MAX: smax_reg  <= wr_data[STR_W-1:0];
                REG_WIDTH:        width_reg <= wr_data[HALF_W-1:0];
                REG_RISE_HALF:    rise_reg  <= wr_data[HALF_W-1:0];
                REG_FALL_HALF:    fall_reg  <= wr_data[HALF_W-1:0];
                REG_TIME_STEP:    step_reg  <= wr_data[HALF_W-1:0];
                REG_PROFILE_MIN:  pmin_reg  <= wr_data[PROF_W-1:0];
                REG_PROFILE_MAX:  pmax_reg  <= wr_data[PROF_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            phase_reg     <= 1'b0;
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            time_reg      <= time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        zr_reg       <= zr_next;
        d_reg        <= d_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        neg_reg      <= neg_next;
        res_reg      <= res_next;
        strength_reg <= strength_next;
        otime_reg    <= otime_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        time_next      = time_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        zr_next        = zr_reg;
        d_next         = d_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        strength_next  = strength_reg;
        otime_next     = otime_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (restart)
                    begin
                        time_next  = '0;
                        res_next   = smin_reg;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        time_next  = time_adv;
                        x_next     = $signed({{(XY_W-HALF_W){1'b0}}, w_eff});
                        y_next     = $signed({{(XY_W-TIME_W){1'b0}}, time_adv})
                                   - $signed({{(XY_W-HALF_W){1'b0}}, rise_reg});
                        z_next     = '0;
                        cnt_next   = '0;
                        phase_next = 1'b0;
                        state_next = ST_CORDIC;
                    end
                end
            end
            ST_CORDIC:
            begin
                x_next   = x_step;
                y_next   = y_step;
                z_next   = z_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                begin
                    cnt_next = '0;
                    if (!phase_reg)
                    begin
                        zr_next    = z_step;
                        x_next     = $signed({{(XY_W-HALF_W){1'b0}}, w_eff});
                        y_next     = $signed({{(XY_W-TIME_W){1'b0}}, time_reg})
                                   - $signed({{(XY_W-HALF_W){1'b0}}, fall_reg});
                        z_next     = '0;
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        d_next = zr_reg - z_step;
                        if (span == '0)
                        begin
                            res_next   = smin_reg;
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_MUL:
            begin
                acc_next   = prod;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                acc_next   = acc_reg[PROD_W-1] ? (~acc_reg + 1'b1) : acc_reg;
                den_next   = span[DEN_W-1] ? (~span + 1'b1) : span;
                neg_next   = acc_reg[PROD_W-1] ^ span[DEN_W-1];
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (!rem_sub[DEN_W])
                begin
                    rem_next = rem_sub[DEN_W-1:0];
                    acc_next = {acc_reg[PROD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[DEN_W-1:0];
                    acc_next = {acc_reg[PROD_W-2:0], 1'b0};
                end
                if (cnt_reg == CNT_W'(DIV_BITS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                if (sum[SUM_W-1:STR_W-1] == '0 || sum[SUM_W-1:STR_W-1] == '1)
                begin
                    res_next = sum[STR_W-1:0];
                end
                else if (sum[SUM_W-1])
                begin
                    res_next = {1'b1, {(STR_W-1){1'b0}}};
                end
                else
                begin
                    res_next = {1'b0, {(STR_W-1){1'b1}}};
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    strength_next  = res_reg;
                    otime_next     = time_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: tb/appg_checker.sv
// Checker that predicts each pulse generator result from the watched requests and compares it.
module appg_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [appg_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [appg_pkg::CFG_DATA_W-1:0] wr_data,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            restart,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [appg_pkg::STR_W-1:0]      strength,
    input  logic [appg_pkg::TIME_W-1:0]     current_time,
    output int                              mismatches,
    output int                              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import appg_pkg::*;

    localparam longint STR_HI = 64'sd2147483647;
    localparam longint STR_LO = -64'sd2147483648;

    typedef struct packed {
        logic [STR_W-1:0]  strength;
        logic [TIME_W-1:0] cur_time;
    } pulse_sample_t;

    pulse_sample_t     expected_samples[$];
    pulse_sample_t     want;
    pulse_sample_t     got;
    longint            step_angle[32];

    logic [STR_W-1:0]  strength_min_r;
    logic [STR_W-1:0]  strength_max_r;
    logic [HALF_W-1:0] width_r;
    logic [HALF_W-1:0] rise_r;
    logic [HALF_W-1:0] fall_r;
    logic [HALF_W-1:0] step_r;
    logic [PROF_W-1:0] profile_min_r;
    logic [PROF_W-1:0] profile_max_r;
    logic [TIME_W-1:0] running_time;

    // Rotation angles atan(2^-i) in Q16.16, rounded; nothing is left beyond step 16.
    initial
    begin
        for (int i = 0; i < 32; i++)
        begin
            if (i > 16)
                step_angle[i] = 0;
            else
                step_angle[i] = longint'($rtoi($atan(2.0 ** (-i)) * 65536.0 + 0.5));
        end
    end

    function automatic longint vector_angle(input longint x_in, input longint y_in);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        x = x_in;
        y = y_in;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + step_angle[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - step_angle[i];
            end
        end
        return z;
    endfunction

    function automatic logic [STR_W-1:0] pulse_strength(input logic [TIME_W-1:0] t_now);
        longint t;
        longint w;
        longint d;
        longint smin;
        longint smax;
        longint pmin;
        longint span;
        longint s;
        t = longint'(t_now);
        w = longint'(width_r);
        if (w == 0)
            w = 1;
        d = vector_angle(w, t - longint'(rise_r)) - vector_angle(w, t - longint'(fall_r));
        smin = longint'($signed(strength_min_r));
        smax = longint'($signed(strength_max_r));
        pmin = longint'($signed(profile_min_r));
        span = longint'($signed(profile_max_r)) - pmin;
        s = smin;
        if (span != 0)
            s = smin + ((smax - smin) * (d - pmin)) / span;
        if (s > STR_HI)
            s = STR_HI;
        if (s < STR_LO)
            s = STR_LO;
        return s[STR_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_min_r = '0;
            strength_max_r = 32'd65536;
            width_r        = 31'd65536;
            rise_r         = '0;
            fall_r         = 31'd65536;
            step_r         = 31'd65536;
            profile_min_r  = '0;
            profile_max_r  = 20'd205887;
            running_time   = '0;
            expected_samples.delete();
            mismatches     = 0;
            outstanding    = 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_STRENGTH_MIN: strength_min_r = wr_data;
                    REG_STRENGTH_MAX: strength_max_r = wr_data;
                    REG_WIDTH:        width_r        = wr_data[HALF_W-1:0];
                    REG_RISE_HALF:    rise_r         = wr_data[HALF_W-1:0];
                    REG_FALL_HALF:    fall_r         = wr_data[HALF_W-1:0];
                    REG_TIME_STEP:    step_r         = wr_data[HALF_W-1:0];
                    REG_PROFILE_MIN:  profile_min_r  = wr_data[PROF_W-1:0];
                    REG_PROFILE_MAX:  profile_max_r  = wr_data[PROF_W-1:0];
                    default:          ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                got.strength = strength;
                got.cur_time = current_time;
                if (expected_samples.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result: strength %0d time %h",
                                 $signed(got.strength), got.cur_time);
                    mismatches++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (got.strength !== want.strength || got.cur_time !== want.cur_time)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: strength exp %0d got %0d, time exp %h got %h",
                                     $signed(want.strength), $signed(got.strength),
                                     want.cur_time, got.cur_time);
                        mismatches++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                if (restart)
                begin
                    running_time  = '0;
                    want.strength = strength_min_r;
                end
                else
                begin
                    running_time  = running_time + TIME_W'(step_r);
                    want.strength = pulse_strength(running_time);
                end
                want.cur_time = running_time;
                expected_samples = {expected_samples, want};
            end

            outstanding = expected_samples.size();
        end
    end

endmodule

FILE: tb/tb.sv
// Testbench top that drives requests, settings and output stalls and reports the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import appg_pkg::*;

    localparam int   STEPS         = 16;
    localparam int   CYCLE_LIMIT   = 1_000_000;
    localparam int   RANDOM_PHASES = 10;
    localparam int   PHASE_ITEMS   = 85;
    localparam int   LONG_HOLD     = 300;
    localparam logic OP_TICK       = 1'b0;
    localparam logic OP_RESTART    = 1'b1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_index = '0;
    logic [CFG_DATA_W-1:0] wr_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  restart = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [STR_W-1:0]      strength;
    logic [TIME_W-1:0]     current_time;
    int                    mismatches;
    int                    outstanding;
    int                    cycle_count = 0;
    int                    requests_sent = 0;
    int                    results_taken = 0;

    always #5 clk = ~clk;

    arctan_pulse_profile_generator_top #(
        .CORDIC_STEPS(STEPS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .restart(restart),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .strength(strength),
        .current_time(current_time)
    );

    appg_checker #(
        .CORDIC_STEPS(STEPS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .restart(restart),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .strength(strength),
        .current_time(current_time),
        .mismatches(mismatches),
        .outstanding(outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_request(input logic op);
        int gap;
        gap = ((requests_sent % 170) < 30) ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= op;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
    endtask

    task automatic apply_settings(input logic [31:0] smin, input logic [31:0] smax,
                                  input logic [31:0] w, input logic [31:0] rise,
                                  input logic [31:0] fall, input logic [31:0] step,
                                  input logic [31:0] pmin, input logic [31:0] pmax);
        write_reg(REG_STRENGTH_MIN, smin);
        write_reg(REG_STRENGTH_MAX, smax);
        write_reg(REG_WIDTH, w);
        write_reg(REG_RISE_HALF, rise);
        write_reg(REG_FALL_HALF, fall);
        write_reg(REG_TIME_STEP, step);
        write_reg(REG_PROFILE_MIN, pmin);
        write_reg(REG_PROFILE_MAX, pmax);
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    // Most phases trace a whole pulse with a matching profile range; every fourth is raw noise.
    task automatic random_settings(input int phase);
        logic [31:0] smin;
        logic [31:0] smax;
        logic [31:0] w;
        logic [31:0] rise;
        logic [31:0] fall;
        logic [31:0] step;
        logic [31:0] pmin;
        logic [31:0] pmax;
        logic [31:0] swap;
        if (phase % 4 == 3)
        begin
            apply_settings($urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom);
        end
        else
        begin
            step = $urandom_range(1 << 10, 1 << 18);
            w    = $urandom_range(1 << 12, 1 << 20);
            rise = step * $urandom_range(0, 30);
            fall = rise + step * $urandom_range(5, 60);
            if (phase % 4 == 1)
            begin
                swap = rise;
                rise = fall;
                fall = swap;
            end
            pmin = 0 - $urandom_range(0, 2000);
            pmax = $urandom_range(150000, 205887);
            if ($urandom_range(0, 9) == 0)
                pmax = pmin;
            smin = $urandom_range(0, 1 << 18) - (1 << 17);
            smax = smin + $urandom_range(0, 1 << 20);
            apply_settings(smin, smax, w, rise, fall, step, pmin, pmax);
        end
    endtask

    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            int hold;
            if (results_taken == 120 || results_taken == 520)
                hold = LONG_HOLD;
            else if ((results_taken % 250) >= 100 && (results_taken % 250) < 150)
                hold = 0;
            else
                hold = $urandom_range(0, 6);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            results_taken++;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        repeat (3) send_request(OP_TICK);
        send_request(OP_RESTART);
        repeat (2) send_request(OP_TICK);
        wait_idle();

        // Extreme strengths, zero width, a wide profile from -262144 to 262144 and a step that wraps the time.
        apply_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'hFFFC_0000, 32'd262144);
        repeat (4) send_request(OP_TICK);
        send_request(OP_RESTART);
        wait_idle();

        apply_settings(32'd0, 32'd65536, 32'd65536, 32'd0, 32'd262144,
                       32'd65536, 32'd5000, 32'd5000);
        repeat (2) send_request(OP_TICK);
        wait_idle();

        // Reversed strengths, half times and profile with a tiny span, so the sum saturates.
        apply_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd524288,
                       32'd131072, 32'd65536, 32'd1, 32'd0);
        repeat (3) send_request(OP_TICK);
        send_request(OP_RESTART);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            random_settings(phase);
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_request(($urandom_range(0, 11) == 0) ? OP_RESTART : OP_TICK);
        end

        wait_idle();
        repeat (100) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
